// ===== rtl/core/scf_pkg.sv =====
// Shared types and constants for the strip cluster finder.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package scf_pkg;

  localparam int CHANNEL_COUNT = 2048;
  localparam int CHAN_W        = $clog2(CHANNEL_COUNT);
  localparam int CHAN_XW       = CHAN_W + 1;
  localparam int PID_W         = 24;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = CHAN_W;
  localparam logic [CFG_IDX_W-1:0] REG_FINDER_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_BOUNDARY = 1'd1;

  localparam logic [1:0]        MODE_RESET     = 2'd1;
  localparam logic [CHAN_W-1:0] BOUNDARY_RESET = CHAN_W'(CHANNEL_COUNT / 2);

  // Result queue.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_IDEAL  = 2'd0,
    MODE_SIMPLE = 2'd1,
    MODE_GAP    = 2'd2
  } mode_t;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic              single_particle;
    logic [PID_W-1:0]  particle_id;
    logic              lower_neighbour_dead;
    logic              last_hit;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] first_strip;
    logic [CHAN_W-1:0] final_strip;
    logic              bridged_gap;
    logic              split_by_particle;
    logic              module_done;
  } cluster_t;

  // Up to two closed clusters come out of one hit.
  typedef struct packed {
    logic [1:0] count;
    cluster_t   res0;
    cluster_t   res1;
  } step_out_t;

endpackage

// ===== rtl/core/scf_if.sv =====
// Request channels of the strip cluster finder: hit input and cluster output.
// Depends on scf_pkg for the payload types.
`timescale 1ns / 1ps

interface scf_in_if;
  import scf_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface scf_out_if;
  import scf_pkg::*;
  logic     valid;
  logic     ready;
  cluster_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/scf_cluster_step.sv =====
// Open-cluster state and the per-hit clustering decision.
// Depends on scf_pkg; instantiated by strip_cluster_finder_unit.
`timescale 1ns / 1ps

module scf_cluster_step (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step_valid,
  input  scf_pkg::in_item_t         item,
  input  logic [1:0]                finder_mode,
  input  logic [scf_pkg::CHAN_W-1:0] side_boundary,
  output scf_pkg::step_out_t        step_out
);
  import scf_pkg::*;

  logic              cluster_open_r, cluster_open_nxt;
  logic [CHAN_W-1:0] open_first_r, open_first_nxt;
  logic [CHAN_W-1:0] open_final_r, open_final_nxt;
  logic [PID_W-1:0]  open_particle_r, open_particle_nxt;
  logic              gap_used_r, gap_used_nxt;

  mode_t              mode;
  logic               take;
  logic               adjacent;
  logic               bridge;
  logic [CHAN_XW-1:0] ch_ext;
  logic [CHAN_XW-1:0] fin_ext;
  logic               a_open;
  logic [CHAN_W-1:0]  a_first;
  logic [CHAN_W-1:0]  a_final;
  logic [PID_W-1:0]   a_pid;
  logic               a_gap;
  logic               close_valid;
  cluster_t           close_res;
  logic               flush;
  cluster_t           flush_res;

  always_comb begin
    case (finder_mode)
      MODE_IDEAL: mode = MODE_IDEAL;
      MODE_GAP:   mode = MODE_GAP;
      default:    mode = MODE_SIMPLE;
    endcase

    take     = !(mode == MODE_IDEAL && !item.single_particle);
    ch_ext   = {1'b0, item.channel};
    fin_ext  = {1'b0, open_final_r};
    adjacent = (ch_ext == fin_ext + CHAN_XW'(1)) && (item.channel != side_boundary);
    // The dead-strip bridge ignores the side boundary on purpose.
    bridge   = (mode == MODE_GAP) && (ch_ext == fin_ext + CHAN_XW'(2)) &&
               item.lower_neighbour_dead && !gap_used_r;

    a_open  = cluster_open_r;
    a_first = open_first_r;
    a_final = open_final_r;
    a_pid   = open_particle_r;
    a_gap   = gap_used_r;

    close_valid                 = 1'b0;
    close_res.first_strip       = open_first_r;
    close_res.final_strip       = open_final_r;
    close_res.bridged_gap       = gap_used_r;
    close_res.split_by_particle = 1'b0;
    close_res.module_done       = 1'b0;

    if (take) begin
      if (!cluster_open_r) begin
        a_open = 1'b1;
        a_first = item.channel;
        a_final = item.channel;
        a_pid = item.particle_id;
        a_gap = 1'b0;
      end else if (adjacent && !(mode == MODE_IDEAL && item.particle_id != open_particle_r)) begin
        a_final = item.channel;
      end else if (!adjacent && bridge) begin
        a_final = item.channel;
        a_gap = 1'b1;
      end else begin
        // Close the open cluster and start a new one on this hit.
        close_valid = 1'b1;
        close_res.split_by_particle = adjacent;
        a_open = 1'b1;
        a_first = item.channel;
        a_final = item.channel;
        a_pid = item.particle_id;
        a_gap = 1'b0;
      end
    end

    flush                       = item.last_hit && a_open;
    flush_res.first_strip       = a_first;
    flush_res.final_strip       = a_final;
    flush_res.bridged_gap       = a_gap;
    flush_res.split_by_particle = 1'b0;
    flush_res.module_done       = 1'b1;

    step_out.count = 2'd0;
    step_out.res0  = flush_res;
    step_out.res1  = flush_res;
    if (step_valid) begin
      if (close_valid) begin
        step_out.res0  = close_res;
        step_out.count = flush ? 2'd2 : 2'd1;
      end else begin
        step_out.count = flush ? 2'd1 : 2'd0;
      end
    end

    cluster_open_nxt  = cluster_open_r;
    open_first_nxt    = open_first_r;
    open_final_nxt    = open_final_r;
    open_particle_nxt = open_particle_r;
    gap_used_nxt      = gap_used_r;
    if (step_valid) begin
      if (flush) begin
        cluster_open_nxt  = 1'b0;
        open_first_nxt    = '0;
        open_final_nxt    = '0;
        open_particle_nxt = '0;
        gap_used_nxt      = 1'b0;
      end else begin
        cluster_open_nxt  = a_open;
        open_first_nxt    = a_first;
        open_final_nxt    = a_final;
        open_particle_nxt = a_pid;
        gap_used_nxt      = a_gap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cluster_open_r  <= 1'b0;
      open_first_r    <= '0;
      open_final_r    <= '0;
      open_particle_r <= '0;
      gap_used_r      <= 1'b0;
    end else begin
      cluster_open_r  <= cluster_open_nxt;
      open_first_r    <= open_first_nxt;
      open_final_r    <= open_final_nxt;
      open_particle_r <= open_particle_nxt;
      gap_used_r      <= gap_used_nxt;
    end
  end

endmodule

// ===== rtl/core/scf_result_queue.sv =====
// Small register queue that takes up to two clusters per cycle and releases
// one per cycle while the receiver is ready. Depends on scf_pkg and scf_if.
`timescale 1ns / 1ps

module scf_result_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  scf_pkg::step_out_t         push,
  output logic [scf_pkg::QCNT_W-1:0] fill,
  scf_out_if.source                  out_ch
);
  import scf_pkg::*;

  cluster_t           entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               pop;
  logic [QPTR_W-1:0]  wr_ptr_2nd;

  assign out_ch.valid = (count_r != '0);
  assign out_ch.data  = entry_r[rd_ptr_r];
  assign fill         = count_r;

  always_comb begin
    pop        = out_ch.valid && out_ch.ready;
    wr_ptr_2nd = wr_ptr_r + QPTR_W'(1);
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.count);
    count_nxt  = count_r + QCNT_W'(push.count) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entry_r[wr_ptr_r] <= push.res0;
    end
    if (push.count == 2'd2) begin
      entry_r[wr_ptr_2nd] <= push.res1;
    end
  end

endmodule

// ===== rtl/core/strip_cluster_finder_unit.sv =====
// Strip cluster finder: groups ascending fired strip channels into clusters.
// A taken hit is held in the staging register, then its clusters go to the result queue.
// Throughput: one hit per cycle; clusters leave at one per cycle through a
// four-entry result queue, so hits closing two clusters or a stalled cluster
// receiver can stall input once more than two entries are in use.
// Reset (synchronous, rst_n low): no open cluster, queue empty, finder_mode
// 1 and side_boundary_channel 1024. Depends on scf_pkg, scf_if and submodules.
`timescale 1ns / 1ps

module strip_cluster_finder_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  scf_in_if.sink                         in_ch,
  scf_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [scf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import scf_pkg::*;

  logic [1:0]        finder_mode_r, finder_mode_nxt;
  logic [CHAN_W-1:0] side_boundary_r, side_boundary_nxt;
  logic              stage_valid_r, stage_valid_nxt;
  in_item_t          stage_item_r;
  logic              advance;
  logic              accept;
  logic [QCNT_W-1:0] fill;
  step_out_t         step_out;

  always_comb begin
    finder_mode_nxt   = finder_mode_r;
    side_boundary_nxt = side_boundary_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_FINDER_MODE:   finder_mode_nxt = cfg_wdata[1:0];
        REG_SIDE_BOUNDARY: side_boundary_nxt = cfg_wdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // The staged hit moves on only when the queue has room for two clusters.
  always_comb begin
    advance         = stage_valid_r && (fill <= QCNT_W'(QUEUE_DEPTH - 2));
    in_ch.ready     = !stage_valid_r || advance;
    accept          = in_ch.valid && in_ch.ready;
    stage_valid_nxt = accept || (stage_valid_r && !advance);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      finder_mode_r   <= MODE_RESET;
      side_boundary_r <= BOUNDARY_RESET;
      stage_valid_r   <= 1'b0;
    end else begin
      finder_mode_r   <= finder_mode_nxt;
      side_boundary_r <= side_boundary_nxt;
      stage_valid_r   <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_item_r <= in_ch.data;
    end
  end

  scf_cluster_step u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_valid    (advance),
    .item          (stage_item_r),
    .finder_mode   (finder_mode_r),
    .side_boundary (side_boundary_r),
    .step_out      (step_out)
  );

  scf_result_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (step_out),
    .fill   (fill),
    .out_ch (out_ch)
  );

endmodule

// ===== bench/scf_cluster_checker.sv =====
// Cluster checker for the strip cluster finder: watches the hit, cluster and
// configuration ports, predicts the closed clusters and compares them.
// Depends on scf_pkg and the request interfaces in scf_if.
`timescale 1ns / 1ps

module scf_cluster_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  scf_in_if                              hit_ch,
  scf_out_if                             cluster_ch,
  input  logic                           cfg_we,
  input  logic [scf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             mismatch_count,
  output int                             clusters_due
);
  import scf_pkg::*;

  logic [1:0]        finder_mode;
  logic [CHAN_W-1:0] boundary_ch;
  logic              cl_open;
  logic [CHAN_W-1:0] first_ch;
  logic [CHAN_W-1:0] final_ch;
  logic [PID_W-1:0]  owner_pid;
  logic              bridged;
  cluster_t          pending_clusters[$];

  function automatic cluster_t closed_cluster(input logic split, input logic done);
    cluster_t c;
    c.first_strip       = first_ch;
    c.final_strip       = final_ch;
    c.bridged_gap       = bridged;
    c.split_by_particle = split;
    c.module_done       = done;
    return c;
  endfunction

  task automatic expect_cluster(input cluster_t c);
    pending_clusters = {pending_clusters, c};
  endtask

  task automatic start_cluster(input in_item_t hit);
    cl_open   = 1'b1;
    first_ch  = hit.channel;
    final_ch  = hit.channel;
    owner_pid = hit.particle_id;
    bridged   = 1'b0;
  endtask

  task automatic clear_cluster;
    cl_open   = 1'b0;
    first_ch  = '0;
    final_ch  = '0;
    owner_pid = '0;
    bridged   = 1'b0;
  endtask

  task automatic predict_clusters(input in_item_t hit);
    mode_t              mode;
    logic               take;
    logic               adjacent;
    logic               bridge;
    logic [CHAN_XW-1:0] next_ch;
    logic [CHAN_XW-1:0] skip_ch;
    // The spare mode code falls back to plain adjacency.
    mode     = (finder_mode > MODE_GAP) ? MODE_SIMPLE : mode_t'(finder_mode);
    take     = (mode != MODE_IDEAL) || hit.single_particle;
    next_ch  = {1'b0, final_ch} + CHAN_XW'(1);
    skip_ch  = {1'b0, final_ch} + CHAN_XW'(2);
    adjacent = ({1'b0, hit.channel} == next_ch) && (hit.channel != boundary_ch);
    // The dead-strip bridge ignores the side boundary.
    bridge   = (mode == MODE_GAP) && ({1'b0, hit.channel} == skip_ch) &&
               hit.lower_neighbour_dead && !bridged;
    if (take) begin
      if (!cl_open) begin
        start_cluster(hit);
      end else if (adjacent) begin
        if (mode == MODE_IDEAL && hit.particle_id != owner_pid) begin
          expect_cluster(closed_cluster(1'b1, 1'b0));
          start_cluster(hit);
        end else begin
          final_ch = hit.channel;
        end
      end else if (bridge) begin
        final_ch = hit.channel;
        bridged  = 1'b1;
      end else begin
        expect_cluster(closed_cluster(1'b0, 1'b0));
        start_cluster(hit);
      end
    end
    if (hit.last_hit && cl_open) begin
      expect_cluster(closed_cluster(1'b0, 1'b1));
      clear_cluster();
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_cluster(input cluster_t got);
    cluster_t want;
    if (pending_clusters.size() == 0) begin
      $display("%0t: no cluster expected, got first %0d final %0d", $time,
               got.first_strip, got.final_strip);
      mismatch_count++;
    end else begin
      want = pending_clusters.pop_front();
      check_field("first_strip", want.first_strip, got.first_strip);
      check_field("final_strip", want.final_strip, got.final_strip);
      check_field("bridged_gap", want.bridged_gap, got.bridged_gap);
      check_field("split_by_particle", want.split_by_particle, got.split_by_particle);
      check_field("module_done", want.module_done, got.module_done);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      finder_mode = MODE_RESET;
      boundary_ch = BOUNDARY_RESET;
      clear_cluster();
      pending_clusters.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_FINDER_MODE) begin
          finder_mode = cfg_wdata[1:0];
        end else if (cfg_index == REG_SIDE_BOUNDARY) begin
          boundary_ch = cfg_wdata;
        end
      end
      if (hit_ch.valid && hit_ch.ready) begin
        predict_clusters(hit_ch.data);
      end
      if (cluster_ch.valid && cluster_ch.ready) begin
        check_cluster(cluster_ch.data);
      end
    end
    clusters_due = pending_clusters.size();
  end

endmodule

// ===== bench/tb_strip_cluster_finder_unit.sv =====
// Top of the strip cluster finder bench: clock, reset, hit and register
// stimulus, random backpressure and the verdict.
// Depends on scf_pkg, scf_if, the block and scf_cluster_checker.
`timescale 1ns / 1ps

module tb_strip_cluster_finder_unit;
  import scf_pkg::*;

  localparam logic [1:0] MODE_SPARE    = 2'd3;
  localparam int         STALL_MAX     = 17;
  localparam int         HIT_TARGET    = 2000;
  localparam int         QUIET_LIMIT   = 2000;
  localparam int         SETTLE_CYCLES = 6;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    mismatch_count;
  int                    clusters_due;
  int                    quiet_cycles = 0;
  int                    hits_taken;
  logic [1:0]            cur_mode;
  logic [CHAN_W-1:0]     cur_boundary;
  bit                    send_calm;
  bit                    take_calm;

  scf_in_if  hit_ch ();
  scf_out_if cluster_ch ();

  strip_cluster_finder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (hit_ch),
    .out_ch    (cluster_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  scf_cluster_checker cluster_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .hit_ch         (hit_ch),
    .cluster_ch     (cluster_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .clusters_due   (clusters_due)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Ends the run if neither channel moves a request for too long.
  always @(posedge clk) begin
    if (!rst_n || (hit_ch.valid && hit_ch.ready) || (cluster_ch.valid && cluster_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Cluster receiver with random stalls and calm stretches.
  initial begin
    int stall;
    cluster_ch.ready = 1'b0;
    take_calm = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
      stall = take_calm ? 0 : $urandom_range(0, STALL_MAX);
      if (stall > 0) begin
        cluster_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      cluster_ch.ready <= 1'b1;
      do @(posedge clk); while (!cluster_ch.valid);
    end
  end

  function automatic in_item_t mk_hit(input int ch, input bit single, input int pid,
                                      input bit dead, input bit last);
    in_item_t h;
    h.channel              = CHAN_W'(ch);
    h.single_particle      = single;
    h.particle_id          = PID_W'(pid);
    h.lower_neighbour_dead = dead;
    h.last_hit             = last;
    return h;
  endfunction

  task automatic send_hit(input in_item_t hit);
    int gap;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      hit_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hit_ch.valid <= 1'b1;
    hit_ch.data  <= hit;
    do @(posedge clk); while (!hit_ch.ready);
    if (cur_mode != MODE_IDEAL || hit.single_particle) hits_taken++;
  endtask

  // Holds off new hits until every predicted cluster is out, then lets the
  // pipeline drain hits that closed nothing.
  task automatic settle;
    hit_ch.valid <= 1'b0;
    @(posedge clk);
    while (clusters_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [1:0] mode, input logic [CHAN_W-1:0] bnd);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FINDER_MODE;
    cfg_wdata <= CFG_DATA_W'(mode);
    @(posedge clk);
    cfg_index <= REG_SIDE_BOUNDARY;
    cfg_wdata <= bnd;
    @(posedge clk);
    cfg_we       <= 1'b0;
    cur_mode     = mode;
    cur_boundary = bnd;
  endtask

  // One module: mostly ascending runs of adjacent or one-apart channels,
  // with jumps, repeats and descents mixed in.
  task automatic send_module(input int n_hits);
    int               chan;
    int               pick;
    logic [PID_W-1:0] pid;
    in_item_t         hit;
    pid = PID_W'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      chan = int'(cur_boundary) - $urandom_range(0, 6);
    end else begin
      chan = $urandom_range(0, CHANNEL_COUNT - 1);
    end
    if (chan < 0) chan = 0;
    for (int i = 0; i < n_hits; i++) begin
      pick = $urandom_range(0, 99);
      if (i > 0) begin
        if (pick < 55) chan += 1;
        else if (pick < 75) chan += 2;
        else if (pick < 93) chan += $urandom_range(3, 60);
        else chan -= $urandom_range(0, 3);
      end
      if (chan < 0 || chan >= CHANNEL_COUNT) chan = $urandom_range(0, CHANNEL_COUNT - 1);
      if ($urandom_range(0, 7) == 0) pid = PID_W'($urandom);
      hit.channel              = CHAN_W'(chan);
      hit.single_particle      = ($urandom_range(0, 9) != 0);
      hit.particle_id          = pid;
      hit.lower_neighbour_dead = (pick >= 55 && pick < 75) ? ($urandom_range(0, 9) < 7)
                                                           : ($urandom_range(0, 4) == 0);
      hit.last_hit             = (i == n_hits - 1);
      send_hit(hit);
    end
  endtask

  initial begin
    logic [1:0] mode;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_FINDER_MODE;
    cfg_wdata    = '0;
    hit_ch.valid = 1'b0;
    hit_ch.data  = '0;
    cur_mode     = MODE_RESET;
    cur_boundary = BOUNDARY_RESET;
    hits_taken   = 0;
    send_calm    = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: repeats, descents, the side boundary and the top channel.
    send_hit(mk_hit(0, 1, 0, 0, 0));
    send_hit(mk_hit(1, 1, 0, 0, 0));
    send_hit(mk_hit(1, 1, 0, 0, 0));
    send_hit(mk_hit(0, 1, 0, 0, 0));
    send_hit(mk_hit(1023, 1, 0, 0, 0));
    send_hit(mk_hit(1024, 1, 0, 0, 0));
    send_hit(mk_hit(1025, 1, 0, 0, 0));
    send_hit(mk_hit(2046, 1, 0, 0, 0));
    send_hit(mk_hit(2047, 1, 0, 0, 0));
    send_hit(mk_hit(0, 1, 0, 0, 1));
    settle();

    // Ideal mode: particle split, skipped hits, skipped last hit, empty module.
    write_config(MODE_IDEAL, '0);
    send_hit(mk_hit(5, 1, 24'hFFFFFF, 0, 0));
    send_hit(mk_hit(6, 1, 24'hFFFFFF, 0, 0));
    send_hit(mk_hit(7, 1, 0, 0, 0));
    send_hit(mk_hit(8, 0, 0, 0, 0));
    send_hit(mk_hit(9, 1, 0, 0, 0));
    send_hit(mk_hit(10, 0, 0, 0, 1));
    send_hit(mk_hit(3, 0, 0, 0, 1));
    send_hit(mk_hit(0, 1, 1, 0, 0));
    send_hit(mk_hit(1, 1, 1, 0, 0));
    settle();

    // Gap mode entered with a cluster still open; one bridge per cluster, also onto the boundary.
    write_config(MODE_GAP, '1);
    send_hit(mk_hit(3, 1, 2, 1, 0));
    send_hit(mk_hit(5, 1, 2, 1, 0));
    send_hit(mk_hit(7, 1, 2, 0, 0));
    send_hit(mk_hit(2045, 1, 2, 1, 0));
    send_hit(mk_hit(2047, 1, 2, 1, 1));
    settle();

    write_config(MODE_SPARE, CHAN_W'(1));
    send_hit(mk_hit(0, 1, 3, 0, 0));
    send_hit(mk_hit(1, 1, 3, 0, 0));
    send_hit(mk_hit(2, 1, 3, 0, 1));

    for (int phase = 0; hits_taken < HIT_TARGET; phase++) begin
      settle();
      case (phase % 4)
        0:       mode = MODE_IDEAL;
        1:       mode = MODE_SIMPLE;
        2:       mode = MODE_GAP;
        default: mode = MODE_SPARE;
      endcase
      write_config(mode, CHAN_W'($urandom_range(0, CHANNEL_COUNT - 1)));
      repeat (40) begin
        send_module($urandom_range(1, 12));
        if ($urandom_range(0, 29) == 0) settle();
      end
    end
    settle();

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
